// File: rtl/core/deq_pkg.sv
// Shared types and codes for the double-ended queue.
package deq_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Request payload
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
  } req_item_t;

  // Result payload
  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
  } rsp_item_t;

  // Outcome of one request, passed from control to the result stage
  typedef struct packed {
    logic    pop_ok;
    status_e status;
  } resp_info_t;

endpackage

// File: rtl/core/double_ended_queue_top.sv
// Double-ended queue over a ring store: top level with result staging.
// A transferred request's result reaches rsp through the store's registered read,
//   waited on by the pending stage, and then through the output register.
// Throughput: one request per cycle while rsp is not stalled; the shared address of the
//   store is used at most once per request, and not at all for a failed one.
// Reset (rst, synchronous): queue empty, both pointers at zero, no result held.
module double_ended_queue_top #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  deq_pkg::req_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output deq_pkg::rsp_item_t  rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                accept;
  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    addr;
  logic [31:0]         wdata, rdata;
  deq_pkg::resp_info_t info;
  logic                pend_valid;
  deq_pkg::resp_info_t pend_info;
  logic                pend_move;

  // Pending stage may empty into the output register when that is free
  assign pend_move = pend_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = pend_valid && !pend_move;
  assign accept    = req_valid && !req_stall;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .wr_en  (wr_en),
    .rd_en  (rd_en),
    .addr   (addr),
    .wdata  (wdata),
    .info   (info)
  );

  deq_ring_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .wr_en (wr_en),
    .rd_en (rd_en),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Pending stage: waits for the store read; read data holds while it waits
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
    if (accept) begin
      pend_info <= info;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pend_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (pend_move) begin
      rsp.pop_value <= pend_info.pop_ok ? rdata : '0;
      rsp.status    <= pend_info.status;
    end
  end

  // Every transfer in lands in the pending stage
  assert property (@(posedge clk) disable iff (rst) accept |=> pend_valid)
    else $error("accepted request not held in pending stage");

  // Only the pending stage holds off new requests
  assert property (@(posedge clk) disable iff (rst) req_stall |-> pend_valid)
    else $error("request stalled with nothing pending");

  // Failed requests carry a zero value
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != deq_pkg::ST_OK) |-> (rsp.pop_value == '0))
    else $error("non-zero value on overflow or underflow");

  // A waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule

// File: rtl/core/deq_ring_mem.sv
// Ring store: one synchronous write port, one registered read port.
module deq_ring_mem #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] addr,
  input  logic [31:0]      wdata,
  output logic [31:0]      rdata
);

  logic [31:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/core/deq_ctrl.sv
// Pointer and occupancy control: decides each request and drives the store.
module deq_ctrl #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3,
  parameter int CNT_W = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  deq_pkg::req_item_t     req,
  output logic                   wr_en,
  output logic                   rd_en,
  output logic [IDX_W-1:0]       addr,
  output logic [31:0]            wdata,
  output deq_pkg::resp_info_t    info
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] occ, occ_next;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             is_full, is_empty;

  // Wrapping neighbours of both ends
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST_IDX : tail - 1'b1;
  assign is_full  = (occ == FULL_CNT);
  assign is_empty = (occ == '0);
  assign wdata    = req.push_value;

  // Request decode
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    occ_next    = occ;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    addr        = head;
    info.pop_ok = 1'b0;
    info.status = deq_pkg::ST_OK;
    case (deq_pkg::req_e'(req.req_type))
      deq_pkg::REQ_PUSH_FRONT: begin
        if (is_full) begin
          info.status = deq_pkg::ST_OVERFLOW;
        end else begin
          head_next = head_dec;
          addr      = head_dec;
          wr_en     = accept;
          occ_next  = occ + 1'b1;
        end
      end
      deq_pkg::REQ_PUSH_REAR: begin
        if (is_full) begin
          info.status = deq_pkg::ST_OVERFLOW;
        end else begin
          addr      = tail;
          tail_next = tail_inc;
          wr_en     = accept;
          occ_next  = occ + 1'b1;
        end
      end
      deq_pkg::REQ_POP_FRONT: begin
        if (is_empty) begin
          info.status = deq_pkg::ST_UNDERFLOW;
        end else begin
          addr        = head;
          head_next   = head_inc;
          rd_en       = accept;
          info.pop_ok = 1'b1;
          occ_next    = occ - 1'b1;
        end
      end
      deq_pkg::REQ_POP_REAR: begin
        if (is_empty) begin
          info.status = deq_pkg::ST_UNDERFLOW;
        end else begin
          tail_next   = tail_dec;
          addr        = tail_dec;
          rd_en       = accept;
          info.pop_ok = 1'b1;
          occ_next    = occ - 1'b1;
        end
      end
      default: begin
        info.status = deq_pkg::ST_OK;
      end
    endcase
  end

  // Pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      occ  <= '0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
      occ  <= occ_next;
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the double-ended queue: directed edges, random traffic, streaming.
`timescale 1ns / 1ps

module testbench;

  localparam int QUEUE_DEPTH  = 8;
  localparam int IDLE_PCT     = 12;
  localparam int REPORT_LIMIT = 10;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  deq_pkg::req_item_t req       = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  deq_pkg::rsp_item_t rsp;

  // Shadow copy of the deque; entries are only read once written
  logic signed [31:0] ring_mem [QUEUE_DEPTH];
  int head_ptr;
  int tail_ptr;
  int fill_level;

  // Results still owed by the block, oldest first
  deq_pkg::rsp_item_t expected_q [$];

  bit idle_enable = 1'b1;
  int fail_count;
  int checked_count;
  int push_count;
  int pop_count;
  int overflow_count;
  int underflow_count;

  double_ended_queue_top #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int ring_next(input int idx);
    return (idx == QUEUE_DEPTH - 1) ? 0 : idx + 1;
  endfunction

  function automatic int ring_prev(input int idx);
    return (idx == 0) ? QUEUE_DEPTH - 1 : idx - 1;
  endfunction

  // Apply one request to the shadow deque and return the result it owes
  function automatic deq_pkg::rsp_item_t apply_request(input deq_pkg::req_item_t item);
    deq_pkg::rsp_item_t result;
    deq_pkg::req_e      kind;
    kind             = deq_pkg::req_e'(item.req_type);
    result.pop_value = '0;
    result.status    = deq_pkg::ST_OK;
    case (kind)
      deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_REAR: begin
        if (fill_level == QUEUE_DEPTH) begin
          result.status = deq_pkg::ST_OVERFLOW;
        end else if (kind == deq_pkg::REQ_PUSH_FRONT) begin
          head_ptr           = ring_prev(head_ptr);
          ring_mem[head_ptr] = item.push_value;
          fill_level++;
        end else begin
          ring_mem[tail_ptr] = item.push_value;
          tail_ptr           = ring_next(tail_ptr);
          fill_level++;
        end
      end
      default: begin
        if (fill_level == 0) begin
          result.status = deq_pkg::ST_UNDERFLOW;
        end else if (kind == deq_pkg::REQ_POP_FRONT) begin
          result.pop_value = ring_mem[head_ptr];
          head_ptr         = ring_next(head_ptr);
          fill_level--;
        end else begin
          tail_ptr         = ring_prev(tail_ptr);
          result.pop_value = ring_mem[tail_ptr];
          fill_level--;
        end
      end
    endcase
    return result;
  endfunction

  // Offer one request, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_request(input deq_pkg::req_e kind, input logic signed [31:0] value);
    deq_pkg::req_item_t noise;
    deq_pkg::req_item_t item;
    deq_pkg::rsp_item_t outcome;
    while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      noise.req_type   = 2'($urandom_range(3));
      noise.push_value = $urandom;
      req_valid <= 1'b0;
      req       <= noise;
      @(negedge clk);
    end
    item.req_type   = kind;
    item.push_value = value;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    outcome = apply_request(item);
    expected_q.push_back(outcome);
    if (kind == deq_pkg::REQ_PUSH_FRONT || kind == deq_pkg::REQ_PUSH_REAR) push_count++;
    else pop_count++;
    if (outcome.status == deq_pkg::ST_OVERFLOW) overflow_count++;
    if (outcome.status == deq_pkg::ST_UNDERFLOW) underflow_count++;
    @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_until_drained();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // Random request: push share set by the caller, values biased to extremes
  task automatic send_random_request(input int push_pct);
    logic signed [31:0] value;
    deq_pkg::req_e      kind;
    case ($urandom_range(7))
      0:       value = 32'sh7FFF_FFFF;
      1:       value = 32'sh8000_0000;
      2:       value = -32'sd1;
      default: value = $urandom;
    endcase
    if ($urandom_range(99) < push_pct)
      kind = $urandom_range(1) ? deq_pkg::REQ_PUSH_REAR : deq_pkg::REQ_PUSH_FRONT;
    else
      kind = $urandom_range(1) ? deq_pkg::REQ_POP_REAR : deq_pkg::REQ_POP_FRONT;
    send_request(kind, value);
  endtask

  // Compare one transfer on rsp with the oldest expectation
  task automatic check_result(input deq_pkg::rsp_item_t got);
    deq_pkg::rsp_item_t want;
    checked_count++;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("[%0t] unexpected result: pop_value %0d status %0d",
                 $time, got.pop_value, got.status);
    end else begin
      want = expected_q.pop_front();
      if (got.pop_value !== want.pop_value || got.status !== want.status) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("[%0t] mismatch: pop_value exp %0d got %0d, status exp %0d got %0d",
                   $time, want.pop_value, got.pop_value, want.status, got.status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) check_result(rsp);
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    rsp_stall <= idle_enable && ($urandom_range(99) < IDLE_PCT);
  end

  // Underflow at both ends, extremes through both ends, full/overflow, draining to empty
  task automatic test_empty_and_full_edges();
    logic signed [31:0] patterns [4];
    patterns = '{32'sh0, -32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA};
    send_request(deq_pkg::REQ_POP_FRONT, 32'sd0);
    send_request(deq_pkg::REQ_POP_REAR, -32'sd1);
    send_request(deq_pkg::REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_request(deq_pkg::REQ_PUSH_REAR, 32'sh8000_0000);
    send_request(deq_pkg::REQ_POP_REAR, 32'sd0);
    send_request(deq_pkg::REQ_POP_FRONT, 32'sd0);
    // alternate ends while filling so the head pointer wraps
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_request(i[0] ? deq_pkg::REQ_PUSH_REAR : deq_pkg::REQ_PUSH_FRONT,
                   (i < 4) ? patterns[i] : $urandom);
    send_request(deq_pkg::REQ_PUSH_FRONT, 32'sh1234_5678);
    send_request(deq_pkg::REQ_PUSH_REAR, -32'sd2);
    for (int i = 0; i < QUEUE_DEPTH / 2; i++) send_request(deq_pkg::REQ_POP_FRONT, $urandom);
    for (int i = 0; i < QUEUE_DEPTH / 2; i++) send_request(deq_pkg::REQ_POP_REAR, $urandom);
    send_request(deq_pkg::REQ_POP_FRONT, 32'sd0);
  endtask

  // Sender holds off until the block has delivered everything
  task automatic test_drain_pause();
    for (int i = 0; i < 5; i++) send_request(deq_pkg::REQ_PUSH_REAR, $urandom);
    wait_until_drained();
    for (int i = 0; i < 5; i++) send_request(deq_pkg::REQ_POP_FRONT, $urandom);
  endtask

  // Runs leaning towards full, towards empty, or balanced
  task automatic test_mixed_traffic(input int n_items);
    int sent;
    int run_len;
    int push_pct;
    sent = 0;
    while (sent < n_items) begin
      run_len = $urandom_range(40, 8);
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < run_len && sent < n_items; i++) begin
        send_random_request(push_pct);
        sent++;
      end
    end
  endtask

  // Back-to-back transfers with no idling on either side
  task automatic test_streaming(input int n_items);
    idle_enable = 1'b0;
    test_mixed_traffic(n_items);
    idle_enable = 1'b1;
  endtask

  initial begin
    head_ptr   = 0;
    tail_ptr   = 0;
    fill_level = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_empty_and_full_edges();
    test_drain_pause();
    test_mixed_traffic(1200);
    test_streaming(215);
    wait_until_drained();
    repeat (4) @(negedge clk);
    $display("Sent %0d requests: %0d pushes, %0d pops, %0d overflows, %0d underflows.",
             push_count + pop_count, push_count, pop_count, overflow_count, underflow_count);
    $display("Checked %0d results with %0d failures.", checked_count, fail_count);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
